/* src/hsv_color_histogram_classifier_macros.svh */
// Assertion macros shared by the HSV color histogram classifier RTL.
`ifndef HSV_COLOR_HISTOGRAM_CLASSIFIER_MACROS_SVH
`define HSV_COLOR_HISTOGRAM_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on clk and gated by rst_n.
`define HCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and gated by rst_n.
`define HCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hch_pkg.sv */
// Package: constants, codes, control struct and helpers of the HSV color histogram classifier.
`timescale 1ns / 1ps
`default_nettype none
package hch_pkg;

  // Counter sizing and fixed levels
  localparam int COUNT_WIDTH     = 24;
  localparam int OUT_CNT_W       = 24;
  localparam int SHARE_W         = 17;
  localparam int CFG_W           = 17;
  localparam int CFG_IDX_W       = 3;
  localparam int PROD_W          = COUNT_WIDTH + SHARE_W;
  localparam int SCALED_W        = COUNT_WIDTH + 16;
  localparam int NUM_COLORS      = 9;
  localparam int COLOR_W         = 4;
  localparam int HALVES_W        = 5;
  localparam logic [7:0] LEVEL_LOW       = 8'd85;
  localparam logic [7:0] LEVEL_HIGH      = 8'd170;
  localparam logic [7:0] MAGENTA_HUE_MAX = 8'd169;

  // Color codes
  localparam logic [COLOR_W-1:0] COL_RED    = 4'd0;
  localparam logic [COLOR_W-1:0] COL_YELLOW = 4'd1;
  localparam logic [COLOR_W-1:0] COL_GREEN  = 4'd2;
  localparam logic [COLOR_W-1:0] COL_CYAN   = 4'd3;
  localparam logic [COLOR_W-1:0] COL_BLUE   = 4'd4;
  localparam logic [COLOR_W-1:0] COL_PURPLE = 4'd5;
  localparam logic [COLOR_W-1:0] COL_BLACK  = 4'd6;
  localparam logic [COLOR_W-1:0] COL_GRAY   = 4'd7;
  localparam logic [COLOR_W-1:0] COL_WHITE  = 4'd8;
  localparam logic [COLOR_W-1:0] COL_LAST   = COLOR_W'(NUM_COLORS - 1);

  // Brightness classes
  localparam logic [1:0] BR_DARK    = 2'd0;
  localparam logic [1:0] BR_NEUTRAL = 2'd1;
  localparam logic [1:0] BR_BRIGHT  = 2'd2;

  // Ranks
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_SEC  = 2'd1;
  localparam logic [1:0] RANK_MAIN = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CYAN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 count;   // accept a pixel word
    logic                 calc;    // form products and brightness verdict
    logic                 report;  // emit one report word
    logic [COLOR_W-1:0]   idx;     // color being reported
    logic                 last;    // final report of the frame
  } hch_cmd_t;

  // Saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] r;
    r = (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
    return r;
  endfunction

  // Counter value seen on a 24-bit output field
  function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] t;
    t = {{OUT_CNT_W{1'b0}}, c};
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/hch_ctrl.sv */
// Controller: sequences pixel counting, product setup and the nine report words.
`timescale 1ns / 1ps
`default_nettype none
module hch_ctrl
  import hch_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_frame_end,
  output logic          busy,
  output hch_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_RPT  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [COLOR_W-1:0]   idx_r, idx_nxt;
  logic                 accept;
  logic                 idx_last;

  assign accept   = start && (state_r == S_IDLE);
  assign idx_last = (idx_r == COL_LAST);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_frame_end) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_RPT;
        idx_nxt   = '0;
      end
      S_RPT: begin
        if (idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + COLOR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Command outputs
  assign busy       = (state_r != S_IDLE);
  assign cmd.count  = accept;
  assign cmd.calc   = (state_r == S_CALC);
  assign cmd.report = (state_r == S_RPT);
  assign cmd.idx    = idx_r;
  assign cmd.last   = (state_r == S_RPT) && idx_last;

endmodule
`default_nettype wire

/* src/hch_dp.sv */
// Datapath: config registers, pixel classifier, saturating counters, rank logic, output word.
`timescale 1ns / 1ps
`default_nettype none
module hch_dp
  import hch_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire hch_cmd_t                cmd,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic [7:0]              in_hue,
  input  wire logic [7:0]              in_saturation,
  input  wire logic [7:0]              in_value,
  output logic                         out_valid,
  output logic [COLOR_W-1:0]           out_color_index,
  output logic [OUT_CNT_W-1:0]         out_color_count,
  output logic [1:0]                   out_rank,
  output logic [1:0]                   out_brightness,
  output logic [HALVES_W-1:0]          out_complexity_halves,
  output logic [OUT_CNT_W-1:0]         out_total_pixels,
  output logic [OUT_CNT_W-1:0]         out_bad_pixels,
  output logic                         out_report_last
);

  // Configuration registers
  logic [7:0]         red_low_r, red_high_r, yellow_r, green_r, cyan_r, blue_r;
  logic [SHARE_W-1:0] main_share_r, sec_share_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_low_r    <= 8'd170;
      red_high_r   <= 8'd10;
      yellow_r     <= 8'd35;
      green_r      <= 8'd85;
      cyan_r       <= 8'd100;
      blue_r       <= 8'd130;
      main_share_r <= SHARE_W'(13107);
      sec_share_r  <= SHARE_W'(3277);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RED_LOW:   red_low_r    <= cfg_data[7:0];
        CFG_RED_HIGH:  red_high_r   <= cfg_data[7:0];
        CFG_YELLOW:    yellow_r     <= cfg_data[7:0];
        CFG_GREEN:     green_r      <= cfg_data[7:0];
        CFG_CYAN:      cyan_r       <= cfg_data[7:0];
        CFG_BLUE:      blue_r       <= cfg_data[7:0];
        CFG_MAIN:      main_share_r <= cfg_data[SHARE_W-1:0];
        CFG_SECONDARY: sec_share_r  <= cfg_data[SHARE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel classification
  logic               col_hit;
  logic [COLOR_W-1:0] col_code;
  logic               bad_hit;
  logic [1:0]         br_code;

  always_comb begin
    col_hit  = 1'b1;
    bad_hit  = 1'b0;
    col_code = COL_BLACK;
    br_code  = BR_DARK;
    if (in_value <= LEVEL_LOW) begin
      col_code = COL_BLACK;
      br_code  = BR_DARK;
    end else begin
      br_code = (in_value <= LEVEL_HIGH) ? BR_NEUTRAL : BR_BRIGHT;
      if (in_saturation <= LEVEL_LOW) begin
        col_code = (in_value <= LEVEL_HIGH) ? COL_GRAY : COL_WHITE;
      end else if (in_hue >= red_low_r || in_hue <= red_high_r) begin
        col_code = COL_RED;
      end else if (in_hue <= yellow_r) begin
        col_code = COL_YELLOW;
      end else if (in_hue <= green_r) begin
        col_code = COL_GREEN;
      end else if (in_hue <= cyan_r) begin
        col_code = COL_CYAN;
      end else if (in_hue <= blue_r) begin
        col_code = COL_BLUE;
      end else if (in_hue <= MAGENTA_HUE_MAX) begin
        col_code = COL_PURPLE;
      end else begin
        col_hit = 1'b0;
        bad_hit = 1'b1;
      end
    end
  end

  // Histogram counters; cleared after the final report word
  logic [COUNT_WIDTH-1:0] color_cnt_r [NUM_COLORS];
  logic [COUNT_WIDTH-1:0] bright_cnt_r [3];
  logic [COUNT_WIDTH-1:0] pix_cnt_r;
  logic [COUNT_WIDTH-1:0] bad_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.last) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        color_cnt_r[i] <= '0;
      end
      for (int j = 0; j < 3; j++) begin
        bright_cnt_r[j] <= '0;
      end
      pix_cnt_r <= '0;
      bad_cnt_r <= '0;
    end else if (cmd.count) begin
      if (col_hit) begin
        color_cnt_r[col_code] <= sat_inc(color_cnt_r[col_code]);
      end
      if (bad_hit) begin
        bad_cnt_r <= sat_inc(bad_cnt_r);
      end
      bright_cnt_r[br_code] <= sat_inc(bright_cnt_r[br_code]);
      pix_cnt_r <= sat_inc(pix_cnt_r);
    end
  end

  // Threshold products and brightness verdict, formed once per frame
  logic [PROD_W-1:0] prod_main_r, prod_sec_r;
  logic [1:0]        verdict_r;
  logic [1:0]        verdict_nxt;

  always_comb begin
    if (bright_cnt_r[BR_NEUTRAL] < bright_cnt_r[BR_DARK] &&
        bright_cnt_r[BR_BRIGHT] < bright_cnt_r[BR_DARK]) begin
      verdict_nxt = BR_DARK;
    end else if (bright_cnt_r[BR_BRIGHT] < bright_cnt_r[BR_NEUTRAL]) begin
      verdict_nxt = BR_NEUTRAL;
    end else begin
      verdict_nxt = BR_BRIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_main_r <= PROD_W'(main_share_r) * PROD_W'(pix_cnt_r);
      prod_sec_r  <= PROD_W'(sec_share_r) * PROD_W'(pix_cnt_r);
      verdict_r   <= verdict_nxt;
    end
  end

  // Rank of the color under report
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [PROD_W-1:0]      scaled;
  logic [1:0]             rank_nxt;
  logic [HALVES_W-1:0]    halves_r, halves_nxt;

  assign cur_cnt = color_cnt_r[cmd.idx];
  assign scaled  = PROD_W'({cur_cnt, 16'h0000});

  always_comb begin
    if (scaled >= prod_main_r) begin
      rank_nxt = RANK_MAIN;
    end else if (scaled >= prod_sec_r) begin
      rank_nxt = RANK_SEC;
    end else begin
      rank_nxt = RANK_NONE;
    end
    halves_nxt = halves_r + HALVES_W'(rank_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      halves_r <= '0;
    end else if (cmd.report) begin
      halves_r <= halves_nxt;
    end
  end

  // Output word register
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_idx_r;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_tot_r, out_bad_r;
  logic [1:0]           out_rank_r, out_br_r;
  logic [HALVES_W-1:0]  out_halves_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_idx_r    <= cmd.idx;
      out_cnt_r    <= to_out(cur_cnt);
      out_rank_r   <= rank_nxt;
      out_br_r     <= verdict_r;
      out_halves_r <= halves_nxt;
      out_tot_r    <= to_out(pix_cnt_r);
      out_bad_r    <= to_out(bad_cnt_r);
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_color_index       = out_idx_r;
  assign out_color_count       = out_cnt_r;
  assign out_rank              = out_rank_r;
  assign out_brightness        = out_br_r;
  assign out_complexity_halves = out_halves_r;
  assign out_total_pixels      = out_tot_r;
  assign out_bad_pixels        = out_bad_r;
  assign out_report_last       = out_last_r;

endmodule
`default_nettype wire

/* src/hsv_color_histogram_classifier.sv */
// Top level of the HSV color histogram classifier: controller, datapath and checks.
//
//   channel  ports                               handshake
//   -------  ----------------------------------  ---------------------------------
//   pixel    in_hue/saturation/value/frame_end   taken when start && !busy
//   report   out_* fields                        out_valid, one cycle per word
//   config   cfg_we, cfg_index, cfg_data         taken when cfg_we, no wait
//
// A pixel without frame_end leaves busy low, so pixels can arrive every
// cycle. The frame_end pixel raises busy, which stays high while the
// controller forms the two share products (17x24 multipliers) and then walks
// the nine color counters. Report words leave through the output register,
// one per cycle. The receiver cannot stall. Reset clears all counters at once.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_color_histogram_classifier_macros.svh"
module hsv_color_histogram_classifier
  import hch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            in_hue,
  input  wire logic [7:0]            in_saturation,
  input  wire logic [7:0]            in_value,
  input  wire logic                  in_frame_end,
  output logic                       out_valid,
  output logic [COLOR_W-1:0]         out_color_index,
  output logic [OUT_CNT_W-1:0]       out_color_count,
  output logic [1:0]                 out_rank,
  output logic [1:0]                 out_brightness,
  output logic [HALVES_W-1:0]        out_complexity_halves,
  output logic [OUT_CNT_W-1:0]       out_total_pixels,
  output logic [OUT_CNT_W-1:0]       out_bad_pixels,
  output logic                       out_report_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  hch_cmd_t cmd;

  hch_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_frame_end (in_frame_end),
    .busy         (busy),
    .cmd          (cmd)
  );

  hch_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_hue                (in_hue),
    .in_saturation         (in_saturation),
    .in_value              (in_value),
    .out_valid             (out_valid),
    .out_color_index       (out_color_index),
    .out_color_count       (out_color_count),
    .out_rank              (out_rank),
    .out_brightness        (out_brightness),
    .out_complexity_halves (out_complexity_halves),
    .out_total_pixels      (out_total_pixels),
    .out_bad_pixels        (out_bad_pixels),
    .out_report_last       (out_report_last)
  );

  // Checks
  `HCH_ASSERT_NEXT(a_frame_end_busy, start && !busy && in_frame_end, busy, "frame end did not start reports")
  `HCH_ASSERT_NOW(a_last_idle, out_valid && out_report_last, !busy, "controller busy after last report")
  `HCH_ASSERT_NOW(a_idle_only_last, !busy && out_valid, out_report_last, "report word while idle")
  `HCH_ASSERT_NEXT(a_idx_step, out_valid && !out_report_last, out_valid && (out_color_index == COLOR_W'($past(out_color_index) + 1)), "report words not consecutive")

endmodule
`default_nettype wire

/* tb/sv/hsv_color_histogram_classifier_tb.sv */
// Testbench for the HSV color histogram classifier: pixel driver, report checker, predictor.
`timescale 1ns / 1ps
module hsv_color_histogram_classifier_tb;
  import hch_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;

  // One pixel word as queued for the driver; hold waits for an empty pipeline
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       frame_end;
    logic       hold;
  } pixel_t;

  // One report word as predicted
  typedef struct packed {
    logic [COLOR_W-1:0]   color;
    logic [OUT_CNT_W-1:0] count;
    logic [1:0]           rank;
    logic [1:0]           bright;
    logic [HALVES_W-1:0]  halves;
    logic [OUT_CNT_W-1:0] total;
    logic [OUT_CNT_W-1:0] bad;
    logic                 tail;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_hue = '0;
  logic [7:0] in_saturation = '0;
  logic [7:0] in_value = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic [COLOR_W-1:0] out_color_index;
  logic [OUT_CNT_W-1:0] out_color_count;
  logic [1:0] out_rank;
  logic [1:0] out_brightness;
  logic [HALVES_W-1:0] out_complexity_halves;
  logic [OUT_CNT_W-1:0] out_total_pixels;
  logic [OUT_CNT_W-1:0] out_bad_pixels;
  logic out_report_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RED_LOW;
  logic [CFG_W-1:0] cfg_data = '0;

  hsv_color_histogram_classifier uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_hue(in_hue),
    .in_saturation(in_saturation),
    .in_value(in_value),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_color_index(out_color_index),
    .out_color_count(out_color_count),
    .out_rank(out_rank),
    .out_brightness(out_brightness),
    .out_complexity_halves(out_complexity_halves),
    .out_total_pixels(out_total_pixels),
    .out_bad_pixels(out_bad_pixels),
    .out_report_last(out_report_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus and expectation stores
  pixel_t  pixel_q[$];
  report_t report_q[$];
  pixel_t  drive_px;
  logic    pix_taken = 1'b0;
  int      gap_pct = 0;
  int      error_count = 0;
  int      cycle_count = 0;

  // Shadow of the configuration registers
  logic [7:0]  red_lo, red_hi, lim_yellow, lim_green, lim_cyan, lim_blue;
  logic [SHARE_W-1:0] share_main, share_sec;

  // Shadow of the histogram counters
  logic [COUNT_WIDTH-1:0] color_cnt [NUM_COLORS];
  logic [COUNT_WIDTH-1:0] level_cnt [3];
  logic [COUNT_WIDTH-1:0] pix_cnt, bad_cnt;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic logic [COUNT_WIDTH-1:0] bumped(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic clear_histogram();
    foreach (color_cnt[k]) color_cnt[k] = '0;
    foreach (level_cnt[k]) level_cnt[k] = '0;
    pix_cnt = '0;
    bad_cnt = '0;
  endtask

  // Classify one pixel into the histogram; a frame end queues nine report words
  task automatic count_pixel(input pixel_t p);
    logic [COLOR_W-1:0] col;
    logic is_bad;
    logic [1:0] lvl, verdict, rank;
    logic [HALVES_W-1:0] halves;
    logic [63:0] scaled, total;
    report_t r;
    is_bad = 1'b0;
    col = COL_BLACK;
    halves = '0;
    if (p.val <= LEVEL_LOW) begin
      lvl = BR_DARK;
    end else begin
      lvl = (p.val <= LEVEL_HIGH) ? BR_NEUTRAL : BR_BRIGHT;
      if (p.sat <= LEVEL_LOW) col = (p.val <= LEVEL_HIGH) ? COL_GRAY : COL_WHITE;
      else if (p.hue >= red_lo || p.hue <= red_hi) col = COL_RED;
      else if (p.hue <= lim_yellow) col = COL_YELLOW;
      else if (p.hue <= lim_green) col = COL_GREEN;
      else if (p.hue <= lim_cyan) col = COL_CYAN;
      else if (p.hue <= lim_blue) col = COL_BLUE;
      else if (p.hue <= MAGENTA_HUE_MAX) col = COL_PURPLE;
      else is_bad = 1'b1;
    end
    if (is_bad) bad_cnt = bumped(bad_cnt);
    else color_cnt[col] = bumped(color_cnt[col]);
    level_cnt[lvl] = bumped(level_cnt[lvl]);
    pix_cnt = bumped(pix_cnt);
    if (!p.frame_end) return;

    // Brightness verdict: dark only when it strictly outnumbers both other levels, ties go brighter
    if (level_cnt[BR_NEUTRAL] < level_cnt[BR_DARK] && level_cnt[BR_BRIGHT] < level_cnt[BR_DARK])
      verdict = BR_DARK;
    else if (level_cnt[BR_BRIGHT] < level_cnt[BR_NEUTRAL])
      verdict = BR_NEUTRAL;
    else
      verdict = BR_BRIGHT;

    total = 64'(pix_cnt);
    for (int k = 0; k < NUM_COLORS; k++) begin
      scaled = 64'(color_cnt[k]) << 16;
      if (scaled >= 64'(share_main) * total) begin
        rank = RANK_MAIN;
        halves += HALVES_W'(2);
      end else if (scaled >= 64'(share_sec) * total) begin
        rank = RANK_SEC;
        halves += HALVES_W'(1);
      end else begin
        rank = RANK_NONE;
      end
      r.color = COLOR_W'(k);
      r.count = OUT_CNT_W'(color_cnt[k]);
      r.rank = rank;
      r.bright = verdict;
      r.halves = halves;
      r.total = OUT_CNT_W'(pix_cnt);
      r.bad = OUT_CNT_W'(bad_cnt);
      r.tail = (k == NUM_COLORS - 1);
      report_q.insert(report_q.size(), r);
    end
    clear_histogram();
  endtask

  // Sample side: config shadow, accepted pixels, report words
  always @(posedge clk) begin
    if (!rst_n) begin
      red_lo <= 8'd170;
      red_hi <= 8'd10;
      lim_yellow <= 8'd35;
      lim_green <= 8'd85;
      lim_cyan <= 8'd100;
      lim_blue <= 8'd130;
      share_main <= 17'd13107;
      share_sec <= 17'd3277;
      clear_histogram();
      pix_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (report_q.size() == 0) begin
          flag_error($sformatf("report word for color %0d with none expected",
                               out_color_index));
        end else begin
          report_t w;
          w = report_q.pop_front();
          check_field("color_index", 32'(out_color_index), 32'(w.color));
          check_field("color_count", 32'(out_color_count), 32'(w.count));
          check_field("rank", 32'(out_rank), 32'(w.rank));
          check_field("brightness", 32'(out_brightness), 32'(w.bright));
          check_field("complexity_halves", 32'(out_complexity_halves), 32'(w.halves));
          check_field("total_pixels", 32'(out_total_pixels), 32'(w.total));
          check_field("bad_pixels", 32'(out_bad_pixels), 32'(w.bad));
          check_field("report_last", 32'(out_report_last), 32'(w.tail));
        end
      end
      if (start && !busy)
        count_pixel('{hue: in_hue, sat: in_saturation, val: in_value,
                      frame_end: in_frame_end, hold: 1'b0});
      pix_taken <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RED_LOW:   red_lo <= cfg_data[7:0];
          CFG_RED_HIGH:  red_hi <= cfg_data[7:0];
          CFG_YELLOW:    lim_yellow <= cfg_data[7:0];
          CFG_GREEN:     lim_green <= cfg_data[7:0];
          CFG_CYAN:      lim_cyan <= cfg_data[7:0];
          CFG_BLUE:      lim_blue <= cfg_data[7:0];
          CFG_MAIN:      share_main <= cfg_data;
          CFG_SECONDARY: share_sec <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Pixel driver: start holds until taken, random gaps between words
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || pix_taken) begin
      if (pixel_q.size() == 0 || $urandom_range(0, 99) < gap_pct ||
          (pixel_q[0].hold && (report_q.size() != 0 || busy))) begin
        start <= 1'b0;
      end else begin
        drive_px = pixel_q.pop_front();
        start <= 1'b1;
        in_hue <= drive_px.hue;
        in_saturation <= drive_px.sat;
        in_value <= drive_px.val;
        in_frame_end <= drive_px.frame_end;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                            input logic fe);
    pixel_q.insert(pixel_q.size(), '{hue: h, sat: s, val: v, frame_end: fe, hold: 1'b0});
  endtask

  // Wait for an empty pipeline, then let in-flight pixels settle
  task automatic settle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || start || busy || report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers; 8-bit registers get junk in the upper data bits
  task automatic write_config(input logic [7:0] rlo, input logic [7:0] rhi,
                              input logic [7:0] y, input logic [7:0] g,
                              input logic [7:0] c, input logic [7:0] b,
                              input logic [SHARE_W-1:0] m, input logic [SHARE_W-1:0] s);
    logic [CFG_W-1:0] vals [8];
    vals[CFG_RED_LOW] = {9'($urandom), rlo};
    vals[CFG_RED_HIGH] = {9'($urandom), rhi};
    vals[CFG_YELLOW] = {9'($urandom), y};
    vals[CFG_GREEN] = {9'($urandom), g};
    vals[CFG_CYAN] = {9'($urandom), c};
    vals[CFG_BLUE] = {9'($urandom), b};
    vals[CFG_MAIN] = m;
    vals[CFG_SECONDARY] = s;
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random pixel biased toward level and band borders
  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [7:0] edges [8];
    edges = '{red_lo, red_hi, lim_yellow, lim_green, lim_cyan, lim_blue,
              MAGENTA_HUE_MAX, MAGENTA_HUE_MAX + 8'd1};
    case ($urandom_range(0, 2))
      0: p.hue = edges[$urandom_range(0, 7)] + 8'($urandom_range(0, 2)) - 8'd1;
      default: p.hue = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: p.val = 8'd0;
      1: p.val = LEVEL_LOW;
      2: p.val = LEVEL_LOW + 8'd1;
      3: p.val = LEVEL_HIGH;
      4: p.val = LEVEL_HIGH + 8'd1;
      5: p.val = 8'd255;
      default: p.val = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: p.sat = 8'd0;
      1: p.sat = LEVEL_LOW;
      2: p.sat = LEVEL_LOW + 8'd1;
      3: p.sat = 8'd255;
      default: p.sat = 8'($urandom);
    endcase
    p.frame_end = 1'b0;
    p.hold = 1'b0;
    return p;
  endfunction

  initial begin
    int n, len;
    logic [7:0] lim [6];
    logic [SHARE_W-1:0] m, s;
    pixel_t p;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    gap_pct = 26;

    // Directed, reset configuration: one-pixel frame, then every band border
    push_pixel(8'd0, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd10, 8'd86, 8'd86, 1'b0);
    push_pixel(8'd11, 8'd86, 8'd86, 1'b0);
    push_pixel(8'd35, 8'd255, 8'd171, 1'b0);
    push_pixel(8'd36, 8'd200, 8'd200, 1'b0);
    push_pixel(8'd85, 8'd200, 8'd170, 1'b0);
    push_pixel(8'd86, 8'd200, 8'd170, 1'b0);
    push_pixel(8'd100, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd101, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd130, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd131, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd169, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd170, 8'd128, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd85, 8'd170, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd85, 1'b1);
    settle();

    // Directed: gap above magenta makes bad hues, main only at full share
    write_config(8'd200, 8'd5, 8'd30, 8'd80, 8'd110, 8'd140, 17'd65536, 17'd0);
    push_pixel(8'd170, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd199, 8'd86, 8'd100, 1'b0);
    push_pixel(8'd200, 8'd86, 8'd100, 1'b0);
    push_pixel(8'd5, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd6, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd141, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    settle();

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 26 : (ph < 4) ? 47 : 0;
      foreach (lim[i]) lim[i] = 8'($urandom);
      if (ph == 2 || ph == 4) lim.sort();
      m = 17'($urandom_range(0, 65536));
      s = 17'($urandom_range(0, m));
      case (ph)
        0: write_config(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 17'd0, 17'd0);
        1: write_config(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                        17'h1FFFF, 17'h1FFFF);
        2: write_config(lim[5], lim[0], lim[1], lim[2], lim[3], lim[4], m, s);
        3: write_config(lim[0], lim[1], lim[2], lim[3], lim[4], lim[5],
                        17'($urandom), 17'($urandom));
        4: write_config(lim[5], lim[0], lim[1], lim[2], lim[3], lim[4], 17'd65536, s);
        default: write_config(8'd170, 8'd10, 8'd35, 8'd85, 8'd100, 8'd130,
                              17'd13107, 17'd3277);
      endcase
      n = 0;
      while (n < 44) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          p = random_pixel();
          p.frame_end = (j == len - 1);
          p.hold = (j == 0) && ($urandom_range(0, 5) == 0);
          pixel_q.insert(pixel_q.size(), p);
        end
        n += len;
      end
      settle();
    end

    if (report_q.size() != 0)
      flag_error($sformatf("%0d report words never arrived", report_q.size()));
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
